// ===== design/fircv_pkg.sv =====
// ----------------------------------------------------------------------------
// fircv_pkg
// shared types and constants of the streaming convolution block
// ----------------------------------------------------------------------------
package fircv_pkg;

    localparam int TAP_COUNT_W = 7;
    localparam int TAP_INDEX_W = 6;
    localparam int RESULT_W    = 38;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAME_MODE = 2'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic                   is_sample;
        logic                   last;
        logic                   same_mode;
        logic [TAP_COUNT_W-1:0] taps;
    } cmd_ctl_t;

endpackage

// ===== design/fircv_if.sv =====
// ----------------------------------------------------------------------------
// fircv_if
// valid/ready channels of the convolution block
// ----------------------------------------------------------------------------
interface fircv_in_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [5:0]                    tap_index;
    logic signed [SAMPLE_BITS-1:0] tap_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output op, output tap_index, output tap_value,
                    output sample, output last_sample, input ready);
    modport sink (input valid, input op, input tap_index, input tap_value,
                  input sample, input last_sample, output ready);
endinterface

interface fircv_out_if ();
    logic               valid;
    logic               ready;
    logic signed [37:0] result;
    logic               last_result;

    modport source (output valid, output result, output last_result, input ready);
    modport sink (input valid, input result, input last_result, output ready);
endinterface

interface fircv_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/fircv_ram.sv =====
// ----------------------------------------------------------------------------
// fircv_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fircv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/fircv_fifo.sv =====
// ----------------------------------------------------------------------------
// fircv_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module fircv_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/fircv_front.sv =====
// ----------------------------------------------------------------------------
// fircv_front
// input acceptance, configuration registers and command classification
// ----------------------------------------------------------------------------
module fircv_front
    import fircv_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fircv_in_if.sink                      samp,
    fircv_cfg_if.sink                     cfg,
    input  logic                          q_full,
    output logic                          push,
    output cmd_ctl_t                      push_ctl,
    output logic [TAP_INDEX_W-1:0]        push_addr,
    output logic signed [SAMPLE_BITS-1:0] push_data
);

    logic [TAP_COUNT_W-1:0] tap_count_reg, tap_count_next;
    logic                   same_mode_reg, same_mode_next;
    logic [TAP_COUNT_W-1:0] taps_in_use;
    logic                   accept;
    logic                   index_ok;

    assign samp.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = samp.valid && samp.ready;
    assign index_ok   = ({1'b0, samp.tap_index} < (TAP_INDEX_W + 1)'(MAX_TAPS));

    // zero taps act as one, too many saturate
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_in_use = TAP_COUNT_W'(1);
        end
        else if (tap_count_reg > TAP_COUNT_W'(MAX_TAPS))
        begin
            taps_in_use = TAP_COUNT_W'(MAX_TAPS);
        end
        else
        begin
            taps_in_use = tap_count_reg;
        end
    end

    // loads to a tap beyond the store are dropped here
    assign push = accept && ((samp.op == OP_SAMPLE) || index_ok);

    always_comb
    begin
        push_ctl.is_sample = (samp.op == OP_SAMPLE);
        push_ctl.last      = samp.last_sample;
        push_ctl.same_mode = same_mode_reg;
        push_ctl.taps      = taps_in_use;
        push_addr          = samp.tap_index;
        push_data          = (samp.op == OP_SAMPLE) ? samp.sample : samp.tap_value;
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        same_mode_next = same_mode_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_TAP_COUNT: tap_count_next = cfg.data[TAP_COUNT_W-1:0];
                REG_SAME_MODE: same_mode_next = cfg.data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            same_mode_reg <= 1'b0;
        end
        else
        begin
            tap_count_reg <= tap_count_next;
            same_mode_reg <= same_mode_next;
        end
    end

endmodule

// ===== design/fircv_back.sv =====
// ----------------------------------------------------------------------------
// fircv_back
// tap store, rotating delay line, multiply-accumulate and result register
// ----------------------------------------------------------------------------
module fircv_back
    import fircv_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  cmd_ctl_t                      q_ctl,
    input  logic [TAP_INDEX_W-1:0]        q_addr,
    input  logic signed [SAMPLE_BITS-1:0] q_data,
    output logic                          q_pop,
    fircv_out_if.source                   res
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = $clog2(MAX_TAPS + 2);
    localparam int PW    = 2 * SAMPLE_BITS;
    localparam int ACC_W = (PW + 6 > RESULT_W) ? PW + 6 : RESULT_W;
    localparam int FW    = TAP_COUNT_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAC    = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] dl_reg [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] dl_next [MAX_TAPS];
    logic [TAP_COUNT_W-1:0]        taps_reg, taps_next;
    logic                          same_reg, same_next;
    logic                          last_reg, last_next;
    logic                          in_flush_reg, in_flush_next;
    logic [TAP_COUNT_W-1:0]        flush_cnt_reg, flush_cnt_next;
    logic [TAP_COUNT_W-2:0]        drop_cnt_reg, drop_cnt_next;
    logic [CW-1:0]                 seq_cnt_reg, seq_cnt_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_BITS-1:0] s1_head_reg;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [RESULT_W-1:0]           pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]           out_result_reg, out_result_next;
    logic                          out_last_reg, out_last_next;

    logic [SAMPLE_BITS-1:0]        tap_rdata;
    logic                          issuing;
    logic [TAP_COUNT_W-1:0]        nb;
    logic                          call_emit;
    logic                          dropping;
    logic                          emitting;
    logic                          slot_free;
    logic                          need_slot;
    logic                          emit_stall;
    logic                          more_flush;
    logic [RESULT_W-1:0]           value;

    fircv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (q_pop && !q_ctl.is_sample),
        .waddr (q_addr[AW-1:0]),
        .wdata (q_data),
        .raddr (seq_cnt_reg[AW-1:0]),
        .rdata (tap_rdata)
    );

    assign q_pop           = (state_reg == ST_IDLE) && q_valid;
    assign res.valid       = out_valid_reg;
    assign res.result      = out_result_reg;
    assign res.last_result = out_last_reg;

    assign issuing       = (state_reg == ST_MAC) && (seq_cnt_reg < CW'(MAX_TAPS));
    assign s1_valid_next = issuing && (TAP_COUNT_W'(seq_cnt_reg) < taps_reg);
    assign prod_next     = s1_valid_reg ? $signed(tap_rdata) * s1_head_reg : PW'(0);

    // same mode: drop the first nb outputs and the tail past nb flush steps
    assign nb         = taps_reg >> 1;
    assign call_emit  = !in_flush_reg || !same_reg || (flush_cnt_reg < nb);
    assign dropping   = same_reg && ({1'b0, drop_cnt_reg} < nb);
    assign emitting   = call_emit && !dropping;
    assign value      = acc_reg[RESULT_W-1:0];
    assign slot_free  = !out_valid_reg || res.ready;
    // within a last item the newest result is held back to tag the final one
    assign need_slot  = emitting && (!last_reg || pend_valid_reg);
    assign emit_stall = need_slot && !slot_free;
    assign more_flush = in_flush_reg
                        ? ((FW'(flush_cnt_reg) + FW'(2)) < FW'(taps_reg))
                        : (taps_reg > TAP_COUNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        dl_next         = dl_reg;
        taps_next       = taps_reg;
        same_next       = same_reg;
        last_next       = last_reg;
        in_flush_next   = in_flush_reg;
        flush_cnt_next  = flush_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        seq_cnt_next    = seq_cnt_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = res.ready ? 1'b0 : out_valid_reg;
        out_result_next = out_result_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && q_ctl.is_sample)
                begin
                    for (int k = MAX_TAPS - 1; k > 0; k--)
                    begin
                        dl_next[k] = dl_reg[k-1];
                    end
                    dl_next[0]     = q_data;
                    taps_next      = q_ctl.taps;
                    same_next      = q_ctl.same_mode;
                    last_next      = q_ctl.last;
                    in_flush_next  = 1'b0;
                    flush_cnt_next = '0;
                    seq_cnt_next   = '0;
                    acc_next       = '0;
                    state_next     = ST_MAC;
                end
            end
            ST_MAC:
            begin
                // rotate so that tap j meets delay entry j at the head
                if (issuing)
                begin
                    for (int k = 0; k < MAX_TAPS - 1; k++)
                    begin
                        dl_next[k] = dl_reg[k+1];
                    end
                    dl_next[MAX_TAPS-1] = dl_reg[0];
                end
                acc_next     = acc_reg + ACC_W'(prod_reg);
                seq_cnt_next = seq_cnt_reg + 1'b1;
                if (seq_cnt_reg == CW'(MAX_TAPS + 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_stall)
                begin
                    if (call_emit && dropping)
                    begin
                        drop_cnt_next = drop_cnt_reg + 1'b1;
                    end
                    if (emitting)
                    begin
                        if (!last_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_result_next = value;
                            out_last_next   = 1'b0;
                        end
                        else
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_result_next = pend_reg;
                                out_last_next   = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = value;
                        end
                    end
                    if (last_reg && more_flush)
                    begin
                        for (int k = MAX_TAPS - 1; k > 0; k--)
                        begin
                            dl_next[k] = dl_reg[k-1];
                        end
                        dl_next[0]     = '0;
                        flush_cnt_next = in_flush_reg ? flush_cnt_reg + 1'b1 : '0;
                        in_flush_next  = 1'b1;
                        seq_cnt_next   = '0;
                        acc_next       = '0;
                        state_next     = ST_MAC;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_result_next = pend_reg;
                        out_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    for (int k = 0; k < MAX_TAPS; k++)
                    begin
                        dl_next[k] = '0;
                    end
                    drop_cnt_next = '0;
                    in_flush_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                dl_reg[k] <= '0;
            end
            taps_reg       <= '0;
            same_reg       <= 1'b0;
            last_reg       <= 1'b0;
            in_flush_reg   <= 1'b0;
            flush_cnt_reg  <= '0;
            drop_cnt_reg   <= '0;
            seq_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            prod_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dl_reg         <= dl_next;
            taps_reg       <= taps_next;
            same_reg       <= same_next;
            last_reg       <= last_next;
            in_flush_reg   <= in_flush_next;
            flush_cnt_reg  <= flush_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            seq_cnt_reg    <= seq_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            prod_reg       <= prod_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_head_reg    <= dl_reg[0];
        acc_reg        <= acc_next;
        pend_reg       <= pend_next;
        out_result_reg <= out_result_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== design/fir_convolution_full_same_unit.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_full_same_unit
// streaming linear convolution, full or same length, with loadable taps
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-----------------------------------------
//   samp    | in  | samp.valid/ready | op, tap_index, tap_value, sample,
//           |     |                  | last_sample
//   res     | out | res.valid/ready  | result, last_result
//   cfg     | in  | cfg.valid/ready  | index (0 tap_count, 1 same_mode), data
//
// a load item is written to the tap store as the back pops it; a sample item
// runs a multiply-accumulate pass, and a last sample item also flushes zeros
// through the delay line for the tail; each pass has one multiplier stepping
// through the tap memory, one tap per cycle, while the delay line rotates past it
// the front accepts items into a two-deep queue while the back is busy
// a full result register stalls the back; reset clears delay line and counters
// ----------------------------------------------------------------------------
module fir_convolution_full_same_unit
    import fircv_pkg::*;
#(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    fircv_in_if.sink     samp,
    fircv_out_if.source  res,
    fircv_cfg_if.sink    cfg
);

    localparam int QW = $bits(cmd_ctl_t) + TAP_INDEX_W + SAMPLE_BITS;

    logic                          push;
    cmd_ctl_t                      push_ctl;
    logic [TAP_INDEX_W-1:0]        push_addr;
    logic signed [SAMPLE_BITS-1:0] push_data;
    logic                          q_full;
    logic                          q_valid;
    logic                          q_pop;
    logic [QW-1:0]                 q_word;
    cmd_ctl_t                      q_ctl;
    logic [TAP_INDEX_W-1:0]        q_addr;
    logic signed [SAMPLE_BITS-1:0] q_data;

    fircv_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samp      (samp),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_addr (push_addr),
        .push_data (push_data)
    );

    fircv_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_addr, push_data}),
        .pop       (q_pop),
        .pop_data  (q_word),
        .full      (q_full),
        .not_empty (q_valid)
    );

    assign {q_ctl, q_addr, q_data} = q_word;

    fircv_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_addr  (q_addr),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .res     (res)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back popped an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> q_valid)
        else $error("pushed item missing from queue");

    a_same_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.index == REG_SAME_MODE
        |=> push_ctl.same_mode == $past(cfg.data[0]))
        else $error("same mode write not taken");

endmodule
